// ===== src/assert_macros.svh =====
// Assertion macros shared by the blur RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check, disabled while reset is high.
`define AST_CHECK(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("blur assertion failed");

// Concurrent check that also holds during reset.
`define AST_CHECK_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) (prop)) \
      else $error("blur assertion failed");

`endif

// ===== src/sra_pkg.sv =====
// Types and constants of the separable recursive alpha blur.
`default_nettype none
package sra_pkg;

   localparam int ALPHA_W    = 8;
   localparam int STATE_W    = 16;
   localparam int FB_W       = 12;
   localparam int GAIN_W     = 6;
   localparam int CSR_DATA_W = 12;
   localparam int CSR_IDX_W  = 1;
   localparam int X_SHIFT    = 6;
   localparam int OUT_SHIFT  = 12;
   // prev*fb + (x << 6) fits in 29 bits, times gain in 35
   localparam int PROD1_W    = 29;
   localparam int PROD2_W    = 35;
   localparam int SCALED_W   = PROD2_W - OUT_SHIFT;

   localparam logic [CSR_IDX_W-1:0] CSR_FEEDBACK = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN     = 1'd1;

   localparam logic [FB_W-1:0]   FB_RESET   = 12'd189;
   localparam logic [GAIN_W-1:0] GAIN_RESET = 6'd16;

   // controller -> datapath
   typedef struct packed {
      logic accept;    // latch request, issue line store read
      logic clr_we;    // clearing pass write
      logic mul1;      // first multiply stage
      logic mul1_h;    // operands of the row filter (else column filter)
      logic mul2_v;    // finish column filter, write line store
      logic mul2_h;    // finish row filter
      logic out_load;  // load result register
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic clr_done;
      logic out_free;
   } status_type;

endpackage
`default_nettype wire

// ===== src/separable_recursive_alpha_blur_top.sv =====
// Top level of the separable recursive alpha blur.
//
//   channel | ports                                        | handshake
//   --------+----------------------------------------------+------------------
//   input   | req_alpha, req_first_in_row, req_first_row   | req_valid/ready
//   result  | rsp_shadow_alpha                             | rsp_valid/ready
//   config  | csr_index, csr_wdata                         | csr_we, no wait
//
// A pixel passes from the request register through the shared filter unit (two registered
// multiply stages), which runs once for the column and once for the row, into the result
// register; a new pixel is taken only once the previous one is in the result register.
// After reset a clearing pass zeroes the line store; no pixel is taken then. A new pixel
// is taken while an earlier result waits; the block stalls only when it finishes a pixel
// while the result register is still full.
`default_nettype none
module separable_recursive_alpha_blur_top
   import sra_pkg::*;
#(
   parameter int MAX_WIDTH = 2048
) (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   csr_we,
   input  wire  [CSR_IDX_W-1:0]  csr_index,
   input  wire  [CSR_DATA_W-1:0] csr_wdata,
   input  wire                   req_valid,
   output logic                  req_ready,
   input  wire  [ALPHA_W-1:0]    req_alpha,
   input  wire                   req_first_in_row,
   input  wire                   req_first_row,
   output logic                  rsp_valid,
   input  wire                   rsp_ready,
   output logic [ALPHA_W-1:0]    rsp_shadow_alpha
);

   localparam int IDX_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

   cmd_type    cmd;
   status_type status;

   sra_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   sra_dp #(
      .MAX_WIDTH (MAX_WIDTH),
      .IDX_W     (IDX_W)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_alpha        (req_alpha),
      .req_first_in_row (req_first_in_row),
      .req_first_row    (req_first_row),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_shadow_alpha (rsp_shadow_alpha),
      .cmd              (cmd),
      .status           (status)
   );

endmodule
`default_nettype wire

// ===== src/sra_ctrl.sv =====
// Sequencing state machine of the alpha blur.
`default_nettype none
`include "assert_macros.svh"
module sra_ctrl
   import sra_pkg::*;
(
   input  wire        clock,
   input  wire        reset,
   input  wire        req_valid,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_VMUL1 = 3'd2;
   localparam logic [2:0] ST_VMUL2 = 3'd3;
   localparam logic [2:0] ST_HMUL1 = 3'd4;
   localparam logic [2:0] ST_HMUL2 = 3'd5;
   localparam logic [2:0] ST_OUT   = 3'd6;

   logic [2:0] state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clr_we = 1'b1;
            if (status.clr_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
            if (req_valid) begin
               state_in = ST_VMUL1;
            end
         end
         ST_VMUL1: begin
            cmd.mul1 = 1'b1;
            state_in = ST_VMUL2;
         end
         ST_VMUL2: begin
            cmd.mul2_v = 1'b1;
            state_in   = ST_HMUL1;
         end
         ST_HMUL1: begin
            cmd.mul1   = 1'b1;
            cmd.mul1_h = 1'b1;
            state_in   = ST_HMUL2;
         end
         ST_HMUL2: begin
            cmd.mul2_h = 1'b1;
            state_in   = ST_OUT;
         end
         ST_OUT: begin
            // wait here while the previous result is still unread
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   `AST_CHECK(a_cmd_onehot, clock, reset,
      $onehot0({cmd.accept, cmd.clr_we, cmd.mul1, cmd.mul2_v, cmd.mul2_h, cmd.out_load}))
   `AST_CHECK(a_accept_starts_pixel, clock, reset,
      (req_valid && req_ready) |=> (state_ff == ST_VMUL1))

endmodule
`default_nettype wire

// ===== src/sra_dp.sv =====
// Datapath of the alpha blur: coefficients, line store, shared filter unit, result register.
`default_nettype none
`include "assert_macros.svh"
module sra_dp
   import sra_pkg::*;
#(
   parameter int MAX_WIDTH = 2048,
   parameter int IDX_W     = 11
) (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    csr_we,
   input  wire  [CSR_IDX_W-1:0]   csr_index,
   input  wire  [CSR_DATA_W-1:0]  csr_wdata,
   input  wire  [ALPHA_W-1:0]     req_alpha,
   input  wire                    req_first_in_row,
   input  wire                    req_first_row,
   output logic                   rsp_valid,
   input  wire                    rsp_ready,
   output logic [ALPHA_W-1:0]     rsp_shadow_alpha,
   input  cmd_type                cmd,
   output status_type             status
);

   localparam logic [IDX_W-1:0] LAST_COL = IDX_W'(MAX_WIDTH - 1);

   logic [FB_W-1:0]    fb_ff;
   logic [GAIN_W-1:0]  gain_ff;
   logic [IDX_W-1:0]   col_idx_ff;
   logic [IDX_W-1:0]   col_ff;
   logic [IDX_W-1:0]   col_sel;
   logic [IDX_W-1:0]   clr_cnt_ff;
   logic [ALPHA_W-1:0] alpha_ff;
   logic               first_in_row_ff;
   logic               first_row_ff;
   logic [STATE_W-1:0] mem [MAX_WIDTH];
   logic [STATE_W-1:0] rd_data_ff;
   logic               mem_we;
   logic [IDX_W-1:0]   mem_waddr;
   logic [STATE_W-1:0] mem_wdata;
   logic [STATE_W-1:0] prev_sel;
   logic [ALPHA_W-1:0] x_sel;
   logic [PROD1_W-1:0] p1_in;
   logic [PROD1_W-1:0] p1_ff;
   logic [PROD2_W-1:0] p2;
   logic [SCALED_W-1:0] scaled;
   logic [STATE_W-1:0] sat;
   logic [STATE_W-1:0] vnew_ff;
   logic [STATE_W-1:0] row_ff;
   logic               rsp_valid_ff;
   logic [ALPHA_W-1:0] rsp_alpha_ff;

   // coefficient registers
   always_ff @(posedge clock) begin
      if (reset) begin
         fb_ff   <= FB_RESET;
         gain_ff <= GAIN_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_FEEDBACK: fb_ff   <= csr_wdata;
            CSR_GAIN:     gain_ff <= csr_wdata[GAIN_W-1:0];
            default: ;
         endcase
      end
   end

   // column tracking
   assign col_sel = req_first_in_row ? '0 : col_idx_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         col_idx_ff <= '0;
         clr_cnt_ff <= '0;
      end else begin
         if (cmd.accept) begin
            col_idx_ff <= (col_sel == LAST_COL) ? '0 : col_sel + 1'b1;
         end
         if (cmd.clr_we) begin
            clr_cnt_ff <= clr_cnt_ff + 1'b1;
         end
      end
   end

   assign status.clr_done = (clr_cnt_ff == LAST_COL);

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         col_ff          <= col_sel;
         alpha_ff        <= req_alpha;
         first_in_row_ff <= req_first_in_row;
         first_row_ff    <= req_first_row;
      end
   end

   // line store: one write port, one registered read port
   assign mem_we    = cmd.clr_we | cmd.mul2_v;
   assign mem_waddr = cmd.clr_we ? clr_cnt_ff : col_ff;
   assign mem_wdata = cmd.clr_we ? '0 : sat;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (cmd.accept) begin
         rd_data_ff <= mem[col_sel];
      end
   end

   // shared filter unit: s = ((s*fb + (x << 6)) * gain) >> 12, saturated
   always_comb begin
      if (cmd.mul1_h) begin
         prev_sel = first_in_row_ff ? '0 : row_ff;
         x_sel    = vnew_ff[ALPHA_W-1:0];
      end else begin
         prev_sel = first_row_ff ? '0 : rd_data_ff;
         x_sel    = alpha_ff;
      end
   end

   assign p1_in  = PROD1_W'(prev_sel) * PROD1_W'(fb_ff)
                 + (PROD1_W'(x_sel) << X_SHIFT);
   assign p2     = PROD2_W'(p1_ff) * PROD2_W'(gain_ff);
   assign scaled = p2[PROD2_W-1:OUT_SHIFT];
   assign sat    = (|scaled[SCALED_W-1:STATE_W]) ? '1 : scaled[STATE_W-1:0];

   always_ff @(posedge clock) begin
      if (cmd.mul1) begin
         p1_ff <= p1_in;
      end
      if (cmd.mul2_v) begin
         vnew_ff <= sat;
      end
      if (cmd.out_load) begin
         rsp_alpha_ff <= row_ff[ALPHA_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.mul2_h) begin
            row_ff <= sat;
         end
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign status.out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_shadow_alpha = rsp_alpha_ff;

   `AST_CHECK(a_no_result_overwrite, clock, reset,
      cmd.out_load |-> (!rsp_valid_ff || rsp_ready))
   `AST_CHECK(a_clear_excludes_pixel, clock, reset,
      cmd.clr_we |-> !(cmd.accept || cmd.mul2_v || cmd.mul2_h))

endmodule
`default_nettype wire

// ===== test/tb_separable_recursive_alpha_blur_top.sv =====
// Testbench for the separable recursive alpha blur: directed table, random frames, scoreboard.
`timescale 1ns / 1ps
module tb_separable_recursive_alpha_blur_top
   import sra_pkg::*;
();

   localparam int COLUMNS         = 2048;
   localparam int NO_CHECK        = -1;
   localparam int RANDOM_PIXELS   = 1630;
   localparam int LONG_ROW        = 96;
   localparam int HOLD_CYCLES     = 200;
   localparam int SETTLE_CYCLES   = 24;
   localparam int WATCHDOG_LIMIT  = 20000;

   typedef struct packed {
      bit              set_cfg;
      bit [FB_W-1:0]   fb;
      bit [GAIN_W-1:0] gain;
      bit [7:0]        alpha;
      bit              fir;
      bit              fr;
      int              want;
   } directed_row_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_FEEDBACK;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [ALPHA_W-1:0]    req_alpha = '0;
   logic                  req_first_in_row = 1'b0;
   logic                  req_first_row = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [ALPHA_W-1:0]    rsp_shadow_alpha;

   // model state
   logic [STATE_W-1:0] column_store [0:COLUMNS-1];
   logic [STATE_W-1:0] row_state = '0;
   logic [10:0]        next_column = '0;
   logic [FB_W-1:0]    fb_coef = FB_RESET;
   logic [GAIN_W-1:0]  gain_coef = GAIN_RESET;

   logic [7:0] shadow_expected [$];

   int  mismatches = 0;
   int  results_checked = 0;
   int  pixels_sent = 0;
   int  csr_writes = 0;
   int  frames = 0;
   int  burst_left = 0;
   int  idle_cycles = 0;
   bit  hold_request = 1'b0;
   bit  hold_done = 1'b0;

   // rows without a typed value are checked against the model
   directed_row_type directed_rows [0:20] = '{
      '{1'b0, 12'd0,    6'd0,  8'd255, 1'b0, 1'b1, 15},   // first pixel after reset, no row mark
      '{1'b0, 12'd0,    6'd0,  8'd0,   1'b1, 1'b1, 0},
      '{1'b0, 12'd0,    6'd0,  8'd255, 1'b1, 1'b1, 15},
      '{1'b0, 12'd0,    6'd0,  8'd128, 1'b0, 1'b1, NO_CHECK},
      '{1'b0, 12'd0,    6'd0,  8'd255, 1'b1, 1'b0, NO_CHECK},
      '{1'b0, 12'd0,    6'd0,  8'd1,   1'b0, 1'b0, NO_CHECK},
      '{1'b0, 12'd0,    6'd0,  8'd255, 1'b0, 1'b0, NO_CHECK},
      '{1'b1, 12'd4095, 6'd0,  8'd255, 1'b1, 1'b0, 0},      // zero gain kills everything
      '{1'b0, 12'd0,    6'd0,  8'd170, 1'b0, 1'b0, 0},
      '{1'b1, 12'd0,    6'd63, 8'd255, 1'b1, 1'b1, 247},
      '{1'b0, 12'd0,    6'd0,  8'd0,   1'b0, 1'b0, 0},
      '{1'b0, 12'd0,    6'd0,  8'd85,  1'b0, 1'b0, NO_CHECK},
      '{1'b1, 12'd4095, 6'd63, 8'd255, 1'b1, 1'b1, 247},
      '{1'b0, 12'd0,    6'd0,  8'd255, 1'b1, 1'b0, NO_CHECK},
      '{1'b0, 12'd0,    6'd0,  8'd255, 1'b1, 1'b0, NO_CHECK}, // column state saturates
      '{1'b0, 12'd0,    6'd0,  8'd255, 1'b0, 1'b0, NO_CHECK},
      '{1'b0, 12'd0,    6'd0,  8'd0,   1'b0, 1'b0, NO_CHECK},
      '{1'b1, 12'd2048, 6'd32, 8'd200, 1'b1, 1'b0, NO_CHECK},
      '{1'b0, 12'd0,    6'd0,  8'd55,  1'b0, 1'b1, NO_CHECK},
      '{1'b0, 12'd0,    6'd0,  8'd254, 1'b1, 1'b1, NO_CHECK},
      '{1'b1, 12'd189,  6'd16, 8'd255, 1'b1, 1'b1, 15}
   };

   separable_recursive_alpha_blur_top #(
      .MAX_WIDTH(COLUMNS)
   ) uut (
      .clock            (clock),
      .reset            (reset),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_alpha        (req_alpha),
      .req_first_in_row (req_first_in_row),
      .req_first_row    (req_first_row),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_shadow_alpha (rsp_shadow_alpha)
   );

   always #1 clock = ~clock;

   function automatic logic [STATE_W-1:0] iir_step(input logic [STATE_W-1:0] prev,
                                                   input logic [7:0] x);
      longint unsigned p, f, g, xs, acc;
      p = prev;
      f = fb_coef;
      g = gain_coef;
      xs = x;
      acc = ((p * f + (xs << X_SHIFT)) * g) >> OUT_SHIFT;
      return (acc > 64'd65535) ? 16'hFFFF : 16'(acc);
   endfunction

   function automatic logic [7:0] filter_pixel(input logic [7:0] a, input bit fir,
                                               input bit fr);
      logic [10:0]        col;
      logic [STATE_W-1:0] vprev, vnew;
      col = fir ? 11'd0 : next_column;
      vprev = fr ? 16'd0 : column_store[col];
      vnew = iir_step(vprev, a);
      column_store[col] = vnew;
      row_state = iir_step(fir ? 16'd0 : row_state, vnew[7:0]);
      next_column = col + 11'd1;   // wraps at the line store size
      return row_state[7:0];
   endfunction

   task automatic report_mismatch(input string what);
      $display("ERROR at %0t: %s", $realtime, what);
      mismatches++;
   endtask

   // Called at a rising edge; returns at a rising edge.
   task automatic send_pixel(input logic [7:0] a, input bit fir, input bit fr, input int want);
      bit         taken;
      int         gap;
      logic [7:0] shadow;
      req_valid <= 1'b1;
      req_alpha <= a;
      req_first_in_row <= fir;
      req_first_row <= fr;
      taken = 1'b0;
      while (!taken) begin
         @(negedge clock);
         taken = req_ready;
         @(posedge clock);
      end
      shadow = filter_pixel(a, fir, fr);
      shadow_expected.push_back(want >= 0 ? 8'(want) : shadow);
      pixels_sent++;
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 16);
      end
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (shadow_expected.size() != 0) @(posedge clock);
      @(posedge clock);
   endtask

   task automatic set_coefs(input logic [FB_W-1:0] fb, input logic [GAIN_W-1:0] g);
      csr_we <= 1'b1;
      csr_index <= CSR_FEEDBACK;
      csr_wdata <= fb;
      @(posedge clock);
      csr_index <= CSR_GAIN;
      csr_wdata <= CSR_DATA_W'(g);
      @(posedge clock);
      csr_we <= 1'b0;
      fb_coef = fb;
      gain_coef = g;
      csr_writes += 2;
   endtask

   // Mostly coefficients derived from a radius in tenths, else extremes or noise.
   task automatic pick_coefs(output logic [FB_W-1:0] fb, output logic [GAIN_W-1:0] g);
      int r10;
      if ($urandom_range(0, 9) < 7) begin
         r10 = $urandom_range(11, 200);
         fb = FB_W'(((r10 - 10) * 63 + 5) / 10);
         g = GAIN_W'((630 + r10 / 2) / r10);
      end else begin
         case ($urandom_range(0, 2))
            0: fb = '0;
            1: fb = '1;
            default: fb = FB_W'($urandom_range(0, 4095));
         endcase
         case ($urandom_range(0, 2))
            0: g = '0;
            1: g = '1;
            default: g = GAIN_W'($urandom_range(0, 63));
         endcase
      end
   endtask

   function automatic logic [7:0] pick_alpha();
      case ($urandom_range(0, 3))
         2: return $urandom_range(0, 1) ? 8'd255 : 8'd0;
         3: return 8'($urandom_range(0, 15));
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // Result check and watchdog; sampled mid-cycle, transfer happens at the next rising edge.
   always @(negedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (shadow_expected.size() == 0) begin
               report_mismatch($sformatf("unexpected result, shadow_alpha %0d",
                                         rsp_shadow_alpha));
            end else begin
               if (rsp_shadow_alpha !== shadow_expected[0])
                  report_mismatch($sformatf("result %0d: shadow_alpha %0d, expected %0d",
                                            results_checked, rsp_shadow_alpha,
                                            shadow_expected[0]));
               void'(shadow_expected.pop_front());
            end
            results_checked++;
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            idle_cycles <= 0;
         end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("Timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
            $display("** separable_recursive_alpha_blur_top: FAILED **");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   // Result side back-pressure: modes of random length, plus one long hold on request.
   initial begin : receiver
      int mode, span;
      @(negedge reset);
      forever begin
         mode = $urandom_range(0, 2);
         span = $urandom_range(16, 160);
         repeat (span) begin
            @(posedge clock);
            if (hold_request && !hold_done) begin
               rsp_ready <= 1'b0;
               repeat (HOLD_CYCLES) @(posedge clock);
               hold_done = 1'b1;
            end else begin
               case (mode)
                  0: rsp_ready <= 1'b1;
                  1: rsp_ready <= ($urandom_range(0, 3) != 0);
                  default: rsp_ready <= ($urandom_range(0, 3) == 0);
               endcase
            end
         end
      end
   end

   initial begin : stimulus
      int          random_pixels, w, h, sel;
      bit          fir, fr, long_row_done;
      logic [FB_W-1:0]   fb;
      logic [GAIN_W-1:0] g;
      foreach (column_store[i]) column_store[i] = '0;
      random_pixels = 0;
      long_row_done = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         if (directed_rows[i].set_cfg) begin
            wait_drained();
            set_coefs(directed_rows[i].fb, directed_rows[i].gain);
         end
         send_pixel(directed_rows[i].alpha, directed_rows[i].fir, directed_rows[i].fr,
                    directed_rows[i].want);
      end

      while (random_pixels < RANDOM_PIXELS) begin
         if (frames == 0 || $urandom_range(0, 2) == 0) begin
            wait_drained();
            pick_coefs(fb, g);
            set_coefs(fb, g);
         end
         sel = $urandom_range(0, 19);
         if (sel < 16) begin
            w = $urandom_range(1, 12);
            h = $urandom_range(1, 6);
         end else if (sel < 19) begin
            w = $urandom_range(13, 64);
            h = $urandom_range(1, 4);
         end else begin
            w = $urandom_range(65, 300);
            h = $urandom_range(1, 2);
         end
         for (int y = 0; y < h; y++) begin
            for (int x = 0; x < w; x++) begin
               fir = (x == 0);
               fr = (y == 0);
               // occasional broken framing
               if ($urandom_range(0, 19) == 0) fir = 1'($urandom_range(0, 1));
               if ($urandom_range(0, 19) == 0) fr = 1'($urandom_range(0, 1));
               send_pixel(pick_alpha(), fir, fr, NO_CHECK);
               random_pixels++;
            end
         end
         frames++;

         // one long row, then a short one; the receiver holds off at the start
         // so the block backs up
         if (!long_row_done && random_pixels >= RANDOM_PIXELS / 2) begin
            wait_drained();
            pick_coefs(fb, g);
            set_coefs(fb, g);
            hold_request = 1'b1;
            for (int i = 0; i < LONG_ROW; i++) begin
               send_pixel(pick_alpha(), i == 0, 1'b0, NO_CHECK);
               random_pixels++;
            end
            for (int i = 0; i < 8; i++) begin
               send_pixel(pick_alpha(), i == 0, 1'b0, NO_CHECK);
               random_pixels++;
            end
            long_row_done = 1'b1;
         end
      end

      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("Sent %0d pixels: %0d directed, %0d random frames, one %0d-pixel held-off row",
               pixels_sent, $size(directed_rows), frames, LONG_ROW);
      $display("%0d register writes, %0d results compared, %0d mismatches",
               csr_writes, results_checked, mismatches);
      if (mismatches == 0 && shadow_expected.size() == 0) begin
         $display("** separable_recursive_alpha_blur_top: PASSED **");
      end else begin
         $display("** separable_recursive_alpha_blur_top: FAILED **");
      end
      $finish;
   end

endmodule
